@@ rtl/core/mrfd_pkg.sv @@
// Package for the meter response frame decoder: frame layout constants,
// configuration register indexes and the decoded result struct. No dependencies.
`default_nettype none

package mrfd_pkg;

  // Frame layout
  localparam int FRAME_LEN     = 21;
  localparam int POS_W         = 5;
  localparam int PAYLOAD_FIRST = 3;
  localparam int PAYLOAD_BYTES = 16;
  localparam int PAYLOAD_IDX_W = 4;

  // Check constants
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  BYTE_COUNT_CODE = 8'h10;

  // Configuration registers
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_ADDR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_FUNC = 4'd1;
  localparam logic [7:0] EXP_ADDR_RESET = 8'h01;
  localparam logic [7:0] EXP_FUNC_RESET = 8'h04;

  // One decoded frame
  typedef struct packed {
    logic        frame_valid;
    logic        crc_ok;
    logic        header_ok;
    logic [15:0] volt_centi;
    logic [15:0] amp_centi;
    logic [31:0] power_deci;
    logic [31:0] energy_whr;
    logic [15:0] high_alarm_word;
    logic [15:0] low_alarm_word;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/mrfd_if.sv @@
// Handshake interfaces of the meter response frame decoder: byte input,
// decoded result output and configuration write. Uses mrfd_pkg.
`default_nettype none

interface mrfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mrfd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_valid;
  logic        crc_ok;
  logic        header_ok;
  logic [15:0] volt_centi;
  logic [15:0] amp_centi;
  logic [31:0] power_deci;
  logic [31:0] energy_whr;
  logic [15:0] high_alarm_word;
  logic [15:0] low_alarm_word;

  modport source (
    output valid, output frame_valid, output crc_ok, output header_ok,
    output volt_centi, output amp_centi, output power_deci, output energy_whr,
    output high_alarm_word, output low_alarm_word, input ready
  );
  modport sink (
    input valid, input frame_valid, input crc_ok, input header_ok,
    input volt_centi, input amp_centi, input power_deci, input energy_whr,
    input high_alarm_word, input low_alarm_word, output ready
  );
endinterface

interface mrfd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mrfd_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mrfd_crc16.sv @@
// Modbus CRC-16 update over one byte (reflected polynomial, eight shift steps).
// Depends on mrfd_pkg for the polynomial.
`default_nettype none

module mrfd_crc16 (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);

  // Unrolled bitwise update, LSB first
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mrfd_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

@@ rtl/core/mrfd_assembler.sv @@
// Frame assembly state: byte position, running CRC, header check and payload
// store; decodes the result on the last byte. Uses mrfd_pkg and mrfd_crc16.
`default_nettype none

module mrfd_assembler (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_fire,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              frame_start,
  input  wire logic [7:0]        exp_addr,
  input  wire logic [7:0]        exp_func,
  output logic                   last_byte,
  output mrfd_pkg::result_t      result
);

  localparam logic [mrfd_pkg::POS_W-1:0] POS_CRC_LO =
    mrfd_pkg::POS_W'(mrfd_pkg::FRAME_LEN - 2);
  localparam logic [mrfd_pkg::POS_W-1:0] POS_LAST =
    mrfd_pkg::POS_W'(mrfd_pkg::FRAME_LEN - 1);
  localparam logic [mrfd_pkg::POS_W-1:0] POS_END =
    mrfd_pkg::POS_W'(mrfd_pkg::FRAME_LEN);
  localparam logic [mrfd_pkg::POS_W-1:0] POS_PL_FIRST =
    mrfd_pkg::POS_W'(mrfd_pkg::PAYLOAD_FIRST);
  localparam logic [mrfd_pkg::POS_W-1:0] POS_PL_END =
    mrfd_pkg::POS_W'(mrfd_pkg::PAYLOAD_FIRST + mrfd_pkg::PAYLOAD_BYTES);

  logic [mrfd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic                       hdr_r, hdr_nxt;
  logic [7:0]                 payload_r [mrfd_pkg::PAYLOAD_BYTES];
  logic [7:0]                 crc_lo_r;

  logic                       restart;
  logic [mrfd_pkg::POS_W-1:0] pos;
  logic [15:0]                crc_base;
  logic                       hdr_base;
  logic [15:0]                crc_upd;
  logic                       pl_wr;
  logic [mrfd_pkg::POS_W-1:0] pl_off;

  // Start of frame restores fresh CRC and header state
  assign restart  = frame_start || (pos_r >= POS_END);
  assign pos      = restart ? '0 : pos_r;
  assign crc_base = restart ? mrfd_pkg::CRC_INIT : crc_r;
  assign hdr_base = restart ? 1'b0 : hdr_r;

  mrfd_crc16 u_crc (
    .crc_in  (crc_base),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign last_byte = (pos == POS_LAST);
  assign pl_wr     = (pos >= POS_PL_FIRST) && (pos < POS_PL_END);
  assign pl_off    = pos - POS_PL_FIRST;

  // Next position, CRC and header flag
  always_comb begin
    crc_nxt = (pos < POS_CRC_LO) ? crc_upd : crc_base;
    case (pos)
      5'd0:    hdr_nxt = (rx_byte == exp_addr);
      5'd1:    hdr_nxt = hdr_base && (rx_byte == exp_func);
      5'd2:    hdr_nxt = hdr_base && (rx_byte == mrfd_pkg::BYTE_COUNT_CODE);
      default: hdr_nxt = hdr_base;
    endcase
    pos_nxt = pos + 5'd1;
    if (last_byte) begin
      pos_nxt = '0;
      crc_nxt = mrfd_pkg::CRC_INIT;
      hdr_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= mrfd_pkg::CRC_INIT;
      hdr_r <= 1'b0;
    end else if (byte_fire) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      hdr_r <= hdr_nxt;
    end
  end

  // Payload and received CRC low byte
  always_ff @(posedge clk) begin
    if (byte_fire && pl_wr) begin
      payload_r[pl_off[mrfd_pkg::PAYLOAD_IDX_W-1:0]] <= rx_byte;
    end
    if (byte_fire && (pos == POS_CRC_LO)) begin
      crc_lo_r <= rx_byte;
    end
  end

  // Decode of the completed frame
  always_comb begin
    logic crc_good;
    crc_good = ({rx_byte, crc_lo_r} == crc_base);
    result.frame_valid     = crc_good && hdr_base;
    result.crc_ok          = crc_good;
    result.header_ok       = hdr_base;
    result.volt_centi      = {payload_r[0], payload_r[1]};
    result.amp_centi       = {payload_r[2], payload_r[3]};
    result.power_deci      = {payload_r[6], payload_r[7], payload_r[4], payload_r[5]};
    result.energy_whr      = {payload_r[10], payload_r[11], payload_r[8], payload_r[9]};
    result.high_alarm_word = {payload_r[12], payload_r[13]};
    result.low_alarm_word  = {payload_r[14], payload_r[15]};
  end

endmodule

`default_nettype wire

@@ rtl/core/meter_response_frame_decoder.sv @@
// Top level of the meter response frame decoder: input register, frame
// assembler and result register. Uses mrfd_pkg, mrfd_if and mrfd_assembler.
//
// Usage:
//   in_chan  : one received byte per word, with frame_start marking byte 0.
//   out_chan : one decoded word per 21-byte frame (flags, voltage, current,
//              power, energy, alarm words), issued on the frame's last byte.
//   cfg_chan : register writes (index 0 expected address, index 1 expected
//              function); always ready, write only while the decoder is idle.
// Throughput: one byte per clock unless a last byte waits on a busy result
// register. Each byte is captured in an input register and then processed by
// the assembler; the one-byte CRC update is the longest path.
// Result: the decoded word is loaded into the result register when the
// assembler processes the last byte, and is held there until it is taken.
// Reset (rst_n low, synchronous): position and header check clear, CRC
// restarts at 0xFFFF, registers return to address 1 and function 4.
// Stall: while a result waits in the output register, bytes keep flowing;
// only the last byte of the next frame holds in the input register until
// the pending result is taken.
`default_nettype none

module meter_response_frame_decoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mrfd_in_if.sink     in_chan,
  mrfd_out_if.source  out_chan,
  mrfd_cfg_if.sink    cfg_chan
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_start_r;
  logic [7:0]        exp_addr_r;
  logic [7:0]        exp_func_r;
  logic              out_valid_r;
  mrfd_pkg::result_t out_r;

  logic              last_byte;
  mrfd_pkg::result_t result;
  logic              s1_go;
  logic              s1_fire;
  logic              in_fire;

  // Configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r <= mrfd_pkg::EXP_ADDR_RESET;
      exp_func_r <= mrfd_pkg::EXP_FUNC_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        mrfd_pkg::REG_EXP_ADDR: exp_addr_r <= cfg_chan.data;
        mrfd_pkg::REG_EXP_FUNC: exp_func_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Stage 1 moves unless it holds a last byte and the result slot is busy
  assign s1_go         = !last_byte || !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && s1_go;
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_chan.rx_byte;
      s1_start_r <= in_chan.frame_start;
    end
  end

  mrfd_assembler u_asm (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_fire   (s1_fire),
    .rx_byte     (s1_byte_r),
    .frame_start (s1_start_r),
    .exp_addr    (exp_addr_r),
    .exp_func    (exp_func_r),
    .last_byte   (last_byte),
    .result      (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && last_byte) begin
      out_r <= result;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.frame_valid     = out_r.frame_valid;
  assign out_chan.crc_ok          = out_r.crc_ok;
  assign out_chan.header_ok       = out_r.header_ok;
  assign out_chan.volt_centi      = out_r.volt_centi;
  assign out_chan.amp_centi       = out_r.amp_centi;
  assign out_chan.power_deci      = out_r.power_deci;
  assign out_chan.energy_whr      = out_r.energy_whr;
  assign out_chan.high_alarm_word = out_r.high_alarm_word;
  assign out_chan.low_alarm_word  = out_r.low_alarm_word;

endmodule

`default_nettype wire

@@ dv/meter_response_frame_decoder_tb.sv @@
// Self-checking testbench for meter_response_frame_decoder: drives response bytes,
// predicts every decoded frame word and compares it field by field with the output.
// Depends on mrfd_pkg, the mrfd_*_if interfaces and the decoder RTL.
`timescale 1ns / 100ps

module meter_response_frame_decoder_tb;

  localparam int PHASES      = 6;
  localparam int PHASE_BYTES = 285;
  localparam int SETTLE      = 8;    // cycles waited after the last predicted word has come out
  localparam int LONG_HOLD   = 240;  // output back-pressure stretch, in cycles
  localparam int DRAIN_LIMIT = 4000;

  // Index with no register behind it; writes there must change nothing
  localparam logic [mrfd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  // Directed table: where a byte comes from and which hand-written result it closes
  typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI} byte_src_t;
  typedef enum logic [1:0] {WANT_NONE, WANT_CLEAN, WANT_BAD_HEADER} want_t;
  typedef enum logic [2:0] {FK_GOOD, FK_BAD_HEADER, FK_BAD_CRC, FK_SHORT, FK_NOISE} frame_kind_t;

  typedef struct packed {
    logic [7:0] b;
    logic       start;
    byte_src_t  src;
    want_t      want;
  } dir_row_t;

  localparam mrfd_pkg::result_t RES_CLEAN = '{
    frame_valid: 1'b1, crc_ok: 1'b1, header_ok: 1'b1,
    volt_centi: 16'hFFFF, amp_centi: 16'h0000,
    power_deci: 32'h8000_0001, energy_whr: 32'hFFFF_FFFF,
    high_alarm_word: 16'h1234, low_alarm_word: 16'hA55A
  };
  localparam mrfd_pkg::result_t RES_BAD_HEADER = '{crc_ok: 1'b1, default: '0};

  // Abandoned partial frame, a clean frame with extreme payload, then a frame
  // that follows without frame_start and carries a wrong address and function.
  localparam int N_DIR = 44;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{8'hFF, 1'b1, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h01, 1'b1, SRC_LIT, WANT_NONE}, '{8'h04, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h10, 1'b0, SRC_LIT, WANT_NONE},
    '{8'hFF, 1'b0, SRC_LIT, WANT_NONE}, '{8'hFF, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h01, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h80, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'hFF, 1'b0, SRC_LIT, WANT_NONE}, '{8'hFF, 1'b0, SRC_LIT, WANT_NONE},
    '{8'hFF, 1'b0, SRC_LIT, WANT_NONE}, '{8'hFF, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h12, 1'b0, SRC_LIT, WANT_NONE}, '{8'h34, 1'b0, SRC_LIT, WANT_NONE},
    '{8'hA5, 1'b0, SRC_LIT, WANT_NONE}, '{8'h5A, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_CRC_LO, WANT_NONE}, '{8'h00, 1'b0, SRC_CRC_HI, WANT_CLEAN},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'hFF, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h10, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_LIT, WANT_NONE}, '{8'h00, 1'b0, SRC_LIT, WANT_NONE},
    '{8'h00, 1'b0, SRC_CRC_LO, WANT_NONE}, '{8'h00, 1'b0, SRC_CRC_HI, WANT_BAD_HEADER}
  };

  logic clk;
  logic rst_n;

  mrfd_in_if  in_chan();
  mrfd_out_if out_chan();
  mrfd_cfg_if cfg_chan();

  meter_response_frame_decoder u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // Frame assembler mirror and register copies
  int unsigned asm_pos     = 0;
  logic [15:0] asm_crc     = mrfd_pkg::CRC_INIT;
  logic        asm_hdr_ok  = 1'b0;
  logic [7:0]  asm_payload [mrfd_pkg::PAYLOAD_BYTES] = '{default: 8'h00};
  logic [7:0]  asm_crc_lo  = 8'h00;
  logic [7:0]  cfg_addr    = mrfd_pkg::EXP_ADDR_RESET;
  logic [7:0]  cfg_func    = mrfd_pkg::EXP_FUNC_RESET;

  mrfd_pkg::result_t decoded_due [$];

  int  mismatches  = 0;
  int  bytes_in    = 0;
  int  frames_out  = 0;
  int  frames_good = 0;
  int  reg_writes  = 0;
  bit  calm          = 1'b0;
  bit  long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("meter_response_frame_decoder_tb: done, errors");
    $finish;
  end

  // Modbus CRC-16, reflected, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ mrfd_pkg::CRC_POLY) : (x >> 1);
    return x;
  endfunction

  // Advance the assembler mirror by one accepted byte; done marks a decoded frame
  task automatic decode_byte(input logic [7:0] b, input logic s,
                             output bit done, output mrfd_pkg::result_t r);
    logic crc_match;
    done = 1'b0;
    r    = '0;
    if (s || asm_pos >= mrfd_pkg::FRAME_LEN) begin
      asm_pos    = 0;
      asm_crc    = mrfd_pkg::CRC_INIT;
      asm_hdr_ok = 1'b0;
    end
    if (asm_pos < mrfd_pkg::FRAME_LEN - 2) asm_crc = crc16_step(asm_crc, b);

    if (asm_pos == 0) asm_hdr_ok = (b == cfg_addr);
    else if (asm_pos == 1) asm_hdr_ok = asm_hdr_ok && (b == cfg_func);
    else if (asm_pos == 2) asm_hdr_ok = asm_hdr_ok && (b == mrfd_pkg::BYTE_COUNT_CODE);
    else if (asm_pos < mrfd_pkg::PAYLOAD_FIRST + mrfd_pkg::PAYLOAD_BYTES)
      asm_payload[asm_pos - mrfd_pkg::PAYLOAD_FIRST] = b;
    else if (asm_pos == mrfd_pkg::FRAME_LEN - 2) asm_crc_lo = b;

    if (asm_pos == mrfd_pkg::FRAME_LEN - 1) begin
      crc_match         = ({b, asm_crc_lo} == asm_crc);
      r.frame_valid     = crc_match && asm_hdr_ok;
      r.crc_ok          = crc_match;
      r.header_ok       = asm_hdr_ok;
      r.volt_centi      = {asm_payload[0], asm_payload[1]};
      r.amp_centi       = {asm_payload[2], asm_payload[3]};
      r.power_deci      = {asm_payload[6], asm_payload[7], asm_payload[4], asm_payload[5]};
      r.energy_whr      = {asm_payload[10], asm_payload[11], asm_payload[8], asm_payload[9]};
      r.high_alarm_word = {asm_payload[12], asm_payload[13]};
      r.low_alarm_word  = {asm_payload[14], asm_payload[15]};
      done       = 1'b1;
      asm_pos    = 0;
      asm_crc    = mrfd_pkg::CRC_INIT;
      asm_hdr_ok = 1'b0;
    end else begin
      asm_pos = asm_pos + 1;
    end
  endtask

  // Offer one byte word, wait for it to be taken, then predict
  task automatic send_byte(input logic [7:0] b, input logic s, input want_t want);
    mrfd_pkg::result_t r;
    bit                done;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.rx_byte     <= b;
    in_chan.frame_start <= s;
    do @(posedge clk); while (!in_chan.ready);
    bytes_in++;
    decode_byte(b, s, done, r);
    if (done) begin
      case (want)
        WANT_CLEAN:      r = RES_CLEAN;
        WANT_BAD_HEADER: r = RES_BAD_HEADER;
        default: ;
      endcase
      decoded_due.push_back(r);
    end
  endtask

  // Mostly well-formed frames; the rest corrupt, cut short or pure noise
  task automatic send_random_frame();
    logic [7:0]  fr [mrfd_pkg::FRAME_LEN];
    logic [7:0]  fill;
    logic [15:0] c;
    frame_kind_t kind;
    bit          flat;
    int          r, n, k;
    r    = $urandom_range(0, 19);
    kind = (r < 12) ? FK_GOOD : (r < 14) ? FK_BAD_HEADER : (r < 16) ? FK_BAD_CRC :
           (r < 18) ? FK_SHORT : FK_NOISE;
    flat = ($urandom_range(0, 9) == 0);
    fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;

    fr[0] = cfg_addr;
    fr[1] = cfg_func;
    fr[2] = mrfd_pkg::BYTE_COUNT_CODE;
    for (k = mrfd_pkg::PAYLOAD_FIRST; k < mrfd_pkg::FRAME_LEN - 2; k++)
      fr[k] = flat ? fill : 8'($urandom_range(0, 255));
    if (kind == FK_BAD_HEADER) begin
      k     = $urandom_range(0, 2);
      fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
    end
    c = mrfd_pkg::CRC_INIT;
    for (k = 0; k < mrfd_pkg::FRAME_LEN - 2; k++) c = crc16_step(c, fr[k]);
    fr[mrfd_pkg::FRAME_LEN-2] = c[7:0];
    fr[mrfd_pkg::FRAME_LEN-1] = c[15:8];
    // one flipped bit anywhere past the header
    if (kind == FK_BAD_CRC) begin
      k     = $urandom_range(mrfd_pkg::PAYLOAD_FIRST, mrfd_pkg::FRAME_LEN - 1);
      fr[k] = fr[k] ^ (8'h01 << $urandom_range(0, 7));
    end

    if (kind == FK_NOISE) begin
      n = $urandom_range(1, 30);
      for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                                        WANT_NONE);
    end else begin
      n = (kind == FK_SHORT) ? $urandom_range(1, mrfd_pkg::FRAME_LEN - 1) : mrfd_pkg::FRAME_LEN;
      // a quarter of frames follow on without frame_start
      for (k = 0; k < n; k++)
        send_byte(fr[k], (k == 0) ? ($urandom_range(0, 3) != 0) : 1'b0, WANT_NONE);
    end
  endtask

  // Stop sending and wait until every predicted word has come out
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && decoded_due.size() != 0; i++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register writes, back to back, valid held across them
  task automatic write_regs(input logic [7:0] addr, input logic [7:0] func, input bit with_unused);
    logic [mrfd_pkg::CFG_IDX_W-1:0] idx [3];
    logic [7:0]                     val [3];
    int                             first;
    idx   = '{REG_UNUSED, mrfd_pkg::REG_EXP_ADDR, mrfd_pkg::REG_EXP_FUNC};
    val   = '{8'($urandom_range(0, 255)), addr, func};
    first = with_unused ? 0 : 1;
    for (int i = first; i < 3; i++) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= idx[i];
      cfg_chan.data  <= val[i];
      do @(posedge clk); while (!cfg_chan.ready);
      if (idx[i] == mrfd_pkg::REG_EXP_ADDR) cfg_addr = val[i];
      else if (idx[i] == mrfd_pkg::REG_EXP_FUNC) cfg_func = val[i];
      reg_writes++;
    end
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Output side back-pressure: random stalls, one long hold on request
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each decoded word with the oldest prediction
  always @(posedge clk) begin : out_check
    mrfd_pkg::result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (decoded_due.size() == 0) begin
        $error("decoded word with none predicted");
        mismatches++;
      end else begin
        want = decoded_due.pop_front();
        check_field("frame_valid", 32'(want.frame_valid), 32'(out_chan.frame_valid));
        check_field("crc_ok", 32'(want.crc_ok), 32'(out_chan.crc_ok));
        check_field("header_ok", 32'(want.header_ok), 32'(out_chan.header_ok));
        check_field("volt_centi", 32'(want.volt_centi), 32'(out_chan.volt_centi));
        check_field("amp_centi", 32'(want.amp_centi), 32'(out_chan.amp_centi));
        check_field("power_deci", want.power_deci, out_chan.power_deci);
        check_field("energy_whr", want.energy_whr, out_chan.energy_whr);
        check_field("high_alarm_word", 32'(want.high_alarm_word),
                    32'(out_chan.high_alarm_word));
        check_field("low_alarm_word", 32'(want.low_alarm_word), 32'(out_chan.low_alarm_word));
        frames_out++;
        if (want.frame_valid) frames_good++;
      end
    end
  end

  // Reset, directed table, then random phases under changing registers
  initial begin : stimulus
    logic [7:0] b;
    int         p;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.rx_byte     <= 8'h00;
    in_chan.frame_start <= 1'b0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.index      <= mrfd_pkg::REG_EXP_ADDR;
    cfg_chan.data       <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      case (DIR_TAB[i].src)
        SRC_CRC_LO: b = asm_crc[7:0];
        SRC_CRC_HI: b = asm_crc[15:8];
        default:    b = DIR_TAB[i].b;
      endcase
      send_byte(b, DIR_TAB[i].start, DIR_TAB[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1:       write_regs(8'h00, 8'h00, 1'b1);
          2:       write_regs(8'hFF, 8'hFF, 1'b0);
          4:       write_regs(mrfd_pkg::EXP_ADDR_RESET, mrfd_pkg::EXP_FUNC_RESET, 1'b1);
          default: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
        endcase
      end
      if (p == 2) long_hold_req = 1'b1;
      if (p == PHASES - 1) calm = 1'b1;
      while (bytes_in < N_DIR + (p + 1) * PHASE_BYTES) send_random_frame();
    end

    wait_idle();
    if (decoded_due.size() != 0) begin
      $error("%0d predicted decoded words never arrived", decoded_due.size());
      mismatches++;
    end

    $display("%0d bytes in, %0d frames decoded (%0d passed every check)",
             bytes_in, frames_out, frames_good);
    $display("%0d register writes across %0d address/function settings, one long output hold",
             reg_writes, PHASES);
    if (mismatches == 0) begin
      $display("meter_response_frame_decoder_tb: done, clean");
    end else begin
      $display("meter_response_frame_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
